/* rtl/core/sci_pkg.sv */
// Package: types, constants and helpers for the segment / circle intersection core.
package sci_pkg;

	localparam int DIR_FRAC = 16;
	localparam int COORD_W  = 32;
	localparam int DIR_W    = 18;
	localparam int REACH_W  = 31;
	localparam int V_W      = 33;
	localparam int H_W      = 36;
	localparam int DISC_W   = 72;
	localparam int ROOT_W   = DISC_W / 2;
	localparam int REM_W    = ROOT_W + 2;
	localparam int T_W      = 38;
	localparam int TP_W     = T_W + DIR_W;

	typedef enum logic [2:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_DIR_X   = 3'd2,
		REG_DIR_Y   = 3'd3,
		REG_REACH   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [REACH_W-1:0]        radius;
	} circle_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      in_front;
		logic                      last;
	} hit_t;

	// start + round(t * dir / 2^16), saturated to 32 bits
	function automatic logic [COORD_W-1:0] place(input logic signed [TP_W-1:0] p,
			input logic signed [COORD_W-1:0] s);
		logic signed [TP_W-1:0] pr;
		logic signed [TP_W-DIR_FRAC:0] v;
		pr = p + TP_W'(32768);
		v = $signed({{(TP_W-DIR_FRAC-COORD_W+1){s[COORD_W-1]}}, s})
			+ $signed(pr[TP_W-1:DIR_FRAC]);
		if (v[TP_W-DIR_FRAC:COORD_W-1] != '0 && v[TP_W-DIR_FRAC:COORD_W-1] != '1) begin
			place = v[TP_W-DIR_FRAC] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			place = v[COORD_W-1:0];
		end
	endfunction

endpackage

/* rtl/core/segment_circle_intersection_core.sv */
// Throughput: one circle per cycle when the output does not stall; a circle with two hits
// holds the pipe while its first beat leaves, since the output gives one beat a cycle.
// The square root is a 36 stage pipeline, one root bit per stage.
// Reset clears all valid bits and loads the configuration registers with their reset values.
module segment_circle_intersection_core import sci_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  circle_t       in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output hit_t          out_data
);

	logic signed [COORD_W-1:0] start_x_q, start_y_q;
	logic signed [DIR_W-1:0]   dir_x_q, dir_y_q;
	logic [REACH_W-1:0]        reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			dir_x_q   <= DIR_W'(65536);
			dir_y_q   <= '0;
			reach_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_DIR_X:   dir_x_q <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:   dir_y_q <= cfg_data[DIR_W-1:0];
				REG_REACH:   reach_q <= cfg_data[REACH_W-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic pend0_q, pend1_q;

	// the pipe moves unless the output still holds a beat it cannot give up
	assign adv = !(pend0_q || pend1_q) || (!out_stall && (pend0_q ^ pend1_q));
	assign in_stall = !adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s7, v_s8;
	logic v_s6 [0:ROOT_W];

	logic signed [V_W-1:0]      vx_s1, vy_s1;
	logic [REACH_W-1:0]         r_s1;
	logic signed [50:0]         px_s2, py_s2;
	logic [61:0]                r2_s2, r2_s3;
	logic signed [65:0]         vx2_s2, vy2_s2;
	logic signed [H_W-1:0]      h_s3, h_s4, h_s5;
	logic [66:0]                neg_s3;
	logic [35:0]                phh_s4, phl_s4, pll_s4;
	logic signed [67:0]         k_s4, k_s5;
	logic [71:0]                h2_s5;
	logic [DISC_W-1:0]          rad_s6  [0:ROOT_W];
	logic [REM_W-1:0]           rem_s6  [0:ROOT_W];
	logic [ROOT_W-1:0]          root_s6 [0:ROOT_W];
	logic signed [H_W-1:0]      h_s6    [0:ROOT_W];
	logic                       ok_s6   [0:ROOT_W];
	logic signed [T_W-1:0]      t1_s7, t2_s7;
	logic                       ok_s7;
	logic signed [TP_W-1:0]     x1_s8, y1_s8, x2_s8, y2_s8;
	logic                       hit1_s8, hit2_s8;
	logic [COORD_W-1:0]         x1_q, y1_q, x2_q, y2_q;

	logic signed [51:0]         hsum;
	logic [H_W-1:0]             hm;
	logic signed [72:0]         disc;
	logic signed [T_W-1:0]      hx, sqx, reach_x;

	assign hsum = px_s2 + py_s2 + 52'sd32768;
	assign hm   = h_s3[H_W-1] ? H_W'(-h_s3) : h_s3;
	assign disc = $signed({1'b0, h2_s5}) + $signed({{5{k_s5[67]}}, k_s5});
	assign hx   = $signed({{(T_W-H_W){h_s6[ROOT_W][H_W-1]}}, h_s6[ROOT_W]});
	assign sqx  = $signed({{(T_W-ROOT_W){1'b0}}, root_s6[ROOT_W]});
	assign reach_x = $signed({{(T_W-REACH_W){1'b0}}, reach_q});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6[0] <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6[0] <= v_s5;
			v_s7 <= v_s6[ROOT_W];
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1  <= $signed({start_x_q[COORD_W-1], start_x_q})
				- $signed({in_data.center_x[COORD_W-1], in_data.center_x});
			vy_s1  <= $signed({start_y_q[COORD_W-1], start_y_q})
				- $signed({in_data.center_y[COORD_W-1], in_data.center_y});
			r_s1   <= in_data.radius;
			px_s2  <= dir_x_q * vx_s1;
			py_s2  <= dir_y_q * vy_s1;
			r2_s2  <= r_s1 * r_s1;
			vx2_s2 <= vx_s1 * vx_s1;
			vy2_s2 <= vy_s1 * vy_s1;
			h_s3   <= hsum[51:DIR_FRAC];
			neg_s3 <= {1'b0, vx2_s2} + {1'b0, vy2_s2};
			r2_s3  <= r2_s2;
			// split |h| in halves to keep each product narrow
			phh_s4 <= hm[35:18] * hm[35:18];
			phl_s4 <= hm[35:18] * hm[17:0];
			pll_s4 <= hm[17:0] * hm[17:0];
			k_s4   <= $signed({6'b0, r2_s3}) - $signed({1'b0, neg_s3});
			h_s4   <= h_s3;
			h2_s5  <= {phh_s4, 36'b0} + {17'b0, phl_s4, 19'b0} + {36'b0, pll_s4};
			k_s5   <= k_s4;
			h_s5   <= h_s4;
			rad_s6[0]  <= disc[DISC_W-1:0];
			rem_s6[0]  <= '0;
			root_s6[0] <= '0;
			h_s6[0]    <= h_s5;
			ok_s6[0]   <= !disc[72];
			t1_s7  <= -hx - sqx;
			t2_s7  <= -hx + sqx;
			ok_s7  <= ok_s6[ROOT_W];
			x1_s8  <= t1_s7 * dir_x_q;
			y1_s8  <= t1_s7 * dir_y_q;
			x2_s8  <= t2_s7 * dir_x_q;
			y2_s8  <= t2_s7 * dir_y_q;
			hit1_s8 <= ok_s7 && !t1_s7[T_W-1] && (t1_s7 <= reach_x);
			hit2_s8 <= ok_s7 && !t2_s7[T_W-1] && (t2_s7 <= reach_x);
		end
	end

	// restoring square root, one root bit per stage
	for (genvar i = 0; i < ROOT_W; i++) begin : g_root
		logic [REM_W+1:0] cur, trial;
		logic ge;
		assign cur   = {rem_s6[i], rad_s6[i][DISC_W-1 -: 2]};
		assign trial = {2'b00, root_s6[i], 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s6[i+1] <= 1'b0;
			end else if (adv) begin
				v_s6[i+1] <= v_s6[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s6[i+1]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
				root_s6[i+1] <= {root_s6[i][ROOT_W-2:0], ge};
				rad_s6[i+1]  <= {rad_s6[i][DISC_W-3:0], 2'b00};
				h_s6[i+1]    <= h_s6[i];
				ok_s6[i+1]   <= ok_s6[i];
			end
		end
	end

	// output: behind beat first, then front beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend0_q <= 1'b0;
			pend1_q <= 1'b0;
		end else if (adv) begin
			pend0_q <= v_s8 && hit1_s8;
			pend1_q <= v_s8 && hit2_s8;
		end else if (!out_stall) begin
			pend0_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_q <= place(x1_s8, start_x_q);
			y1_q <= place(y1_s8, start_y_q);
			x2_q <= place(x2_s8, start_x_q);
			y2_q <= place(y2_s8, start_y_q);
		end
	end

	assign out_valid = pend0_q || pend1_q;

	always_comb begin
		if (pend0_q) begin
			out_data.point_x  = x1_q;
			out_data.point_y  = y1_q;
			out_data.in_front = 1'b0;
			out_data.last     = !pend1_q;
		end else begin
			out_data.point_x  = x2_q;
			out_data.point_y  = y2_q;
			out_data.in_front = 1'b1;
			out_data.last     = 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s8) && $stable(v_s1))
		else $error("pipeline moved while held");
	a_first_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !out_data.in_front)
		else $error("non-final beat is not the behind point");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=> out_valid && out_data.in_front)
		else $error("front beat missing after behind beat");
`endif

endmodule
